FILE: hdl/lis_level_tracker_top_macros.svh
// Assertion macros for the LIS level tracker.
`ifndef LIS_LEVEL_TRACKER_TOP_MACROS_SVH
`define LIS_LEVEL_TRACKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LIS_ASSERT_NOW(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
    else $error("assertion failed");
`define LIS_ASSERT_NEXT(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define LIS_ASSERT_NOW(name, clock, reset, pre, post)
`define LIS_ASSERT_NEXT(name, clock, reset, pre, post)
`endif
`endif

FILE: hdl/lis_pkg.sv
// Shared types and constants for the LIS level tracker.
`default_nettype none
package lis_pkg;
  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int LEVEL_W = 9;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] longest;
    logic               overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic more;
    logic out_free;
  } dp_status_t;
endpackage
`default_nettype wire

FILE: hdl/lis_level_tracker_top.sv
// Top level of the LIS level tracker.
`default_nettype none
`include "lis_level_tracker_top_macros.svh"
// Streams signed 32-bit values and, for each, reports the length of the longest
// strictly increasing subsequence ending there plus the running longest of the
// current sequence; last_item closes a sequence. One word is handled at a time:
// it is loaded, then makes k binary-search probes into the single-port tail
// memory (k is at most ceil(log2(count+1)), so at most 9 for 256 tails, and 0
// for an empty store), each probe costing one registered memory read and one
// compare, and is then committed. The commit cycle repeats while a stalled result
// holds the output register; otherwise a finished result sits there and the next
// word can be taken while it waits. If the store is full and the value exceeds
// every tail, overflow is set, level reads 256 and nothing is written.
module lis_level_tracker_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lis_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lis_pkg::out_item_t     out_data
);
  lis_pkg::dp_cmd_t    cmd;
  lis_pkg::dp_status_t status;
  logic                busy;

  assign in_stall = busy;

  lis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  lis_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `LIS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `LIS_ASSERT_NOW(a_ovf_level, clk, rst, out_valid && out_data.overflow, out_data.level == lis_pkg::LEVEL_W'(lis_pkg::DEPTH))
  `LIS_ASSERT_NOW(a_level_le_longest, clk, rst, out_valid && !out_data.overflow, out_data.level <= out_data.longest)
endmodule
`default_nettype wire

FILE: hdl/lis_ctrl.sv
// Sequencer for the binary search and commit of one word.
`default_nettype none
module lis_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire lis_pkg::dp_status_t status,
  output lis_pkg::dp_cmd_t         cmd,
  output logic                     busy
);
  lis_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= lis_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lis_pkg::ST_IDLE: begin
        if (in_valid) state_next = status.count_zero ? lis_pkg::ST_COMMIT : lis_pkg::ST_READ;
      end
      lis_pkg::ST_READ:   state_next = lis_pkg::ST_CMP;
      lis_pkg::ST_CMP:    state_next = status.more ? lis_pkg::ST_READ : lis_pkg::ST_COMMIT;
      lis_pkg::ST_COMMIT: begin
        if (status.out_free) state_next = lis_pkg::ST_IDLE;
      end
      default:            state_next = lis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != lis_pkg::ST_IDLE);
    cmd.load   = (state == lis_pkg::ST_IDLE) && in_valid;
    cmd.step   = (state == lis_pkg::ST_CMP);
    cmd.commit = (state == lis_pkg::ST_COMMIT) && status.out_free;
  end
endmodule
`default_nettype wire

FILE: hdl/lis_dp.sv
// Tail memory, search bounds, counters and result register.
`default_nettype none
module lis_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lis_pkg::in_item_t   in_data,
  input  wire lis_pkg::dp_cmd_t    cmd,
  output lis_pkg::dp_status_t      status,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lis_pkg::out_item_t       out_data
);
  logic signed [lis_pkg::VALUE_W-1:0] tails [lis_pkg::DEPTH];
  logic signed [lis_pkg::VALUE_W-1:0] rdata;
  logic signed [lis_pkg::VALUE_W-1:0] value;
  logic                               last_item;
  logic [lis_pkg::CNT_W-1:0]          lo, hi, lo_next, hi_next, mid;
  logic [lis_pkg::CNT_W:0]            sum;
  logic [lis_pkg::CNT_W-1:0]          count, count_next;
  logic [lis_pkg::LEVEL_W-1:0]        best, best_next, level;
  logic                               ovf;

  assign sum = {1'b0, lo} + {1'b0, hi};
  assign mid = sum[lis_pkg::CNT_W:1];

  // tails[mid] < value moves the lower bound past mid
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (rdata < value) lo_next = mid + lis_pkg::CNT_W'(1);
    else               hi_next = mid;
  end

  always_comb begin
    ovf        = (lo == lis_pkg::CNT_W'(lis_pkg::DEPTH));
    count_next = count;
    if (!ovf && lo == count) count_next = count + lis_pkg::CNT_W'(1);
    level      = ovf ? lis_pkg::LEVEL_W'(lis_pkg::DEPTH)
                     : lis_pkg::LEVEL_W'(lo + lis_pkg::CNT_W'(1));
    best_next  = (!ovf && level > best) ? level : best;
  end

  assign status.count_zero = (count == '0);
  assign status.more       = (lo_next < hi_next);
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    rdata <= tails[mid[lis_pkg::ADDR_W-1:0]];
    if (cmd.commit && !ovf) tails[lo[lis_pkg::ADDR_W-1:0]] <= value;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value     <= in_data.value;
      last_item <= in_data.last_item;
      lo        <= '0;
      hi        <= count;
    end else if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (cmd.commit) begin
      out_data.level    <= level;
      out_data.longest  <= best_next;
      out_data.overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count     <= last_item ? '0 : count_next;
        best      <= last_item ? '0 : best_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: test/lis_level_tracker_top_tb.sv
// Self-checking testbench for the LIS level tracker top level.
`default_nettype none
module lis_level_tracker_top_tb;
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lis_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lis_pkg::out_item_t out_data;

  lis_level_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Predictor state: sorted tails, live tail count, running longest level.
  logic signed [lis_pkg::VALUE_W-1:0] tail_val [lis_pkg::DEPTH];
  int unsigned tail_cnt = 0;
  int unsigned best_len = 0;

  lis_pkg::in_item_t  value_queue [$];
  lis_pkg::out_item_t level_queue [$];

  int total_words = -1;
  int words_taken = 0;
  int seq_closed  = 0;
  int ovf_seen    = 0;
  int peak_level  = 0;
  int errors      = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int stall_run   = 0;

  // Lower-bound placement of one value into the tail array.
  function automatic lis_pkg::out_item_t track_value(lis_pkg::in_item_t w);
    int pos;
    logic signed [lis_pkg::VALUE_W-1:0] v;
    lis_pkg::out_item_t r;
    pos = 0;
    v = $signed(w.value);
    r = '0;
    while (pos < tail_cnt && tail_val[pos] < v) pos++;
    if (pos < tail_cnt) begin
      tail_val[pos] = v;
      r.level = lis_pkg::LEVEL_W'(pos + 1);
    end else if (tail_cnt < lis_pkg::DEPTH) begin
      tail_val[tail_cnt] = v;
      tail_cnt++;
      r.level = lis_pkg::LEVEL_W'(tail_cnt);
    end else begin
      r.overflow = 1'b1;
      r.level = lis_pkg::LEVEL_W'(lis_pkg::DEPTH);
    end
    if (!r.overflow && r.level > best_len) best_len = r.level;
    r.longest = lis_pkg::LEVEL_W'(best_len);
    if (w.last_item) begin
      tail_cnt = 0;
      best_len = 0;
    end
    return r;
  endfunction

  function automatic void add_word(int v, bit last);
    lis_pkg::in_item_t w;
    w.value = v;
    w.last_item = last;
    value_queue.push_back(w);
  endfunction

  function automatic int pick_value(int style);
    case (style)
      0:       return int'($urandom_range(16)) - 8;
      1:       return int'($urandom());
      default: return int'($urandom_range(1000)) - 500;
    endcase
  endfunction

  // 256 strictly rising tails, then equal, inside and (if !top_at_max) higher words.
  function automatic void fill_store(bit top_at_max);
    int step;
    int base;
    step = $urandom_range(1, 1000);
    if (top_at_max) base = 2147483647 - 255 * step;
    else base = -2147483648 + int'($urandom_range(1000));
    for (int i = 0; i < lis_pkg::DEPTH; i++) add_word(base + i * step, 1'b0);
    if (top_at_max) begin
      add_word(2147483647, 1'b0);
      add_word(base + 254 * step + 1, 1'b0);
      add_word(base + 10 * step, 1'b0);
      add_word(2147483647, 1'b1);
    end else begin
      add_word(base + 255 * step + 1 + int'($urandom_range(500)), 1'b0);
      add_word(base + 255 * step, 1'b0);
      add_word(base + 5 * step - 1, 1'b0);
      add_word(2147483647, 1'b0);
      add_word(base + 255 * step + 1, 1'b1);
    end
  endfunction

  function automatic void build_stimulus();
    int kind;
    int len;
    int style;
    int walk;
    int fills;
    fills = 0;
    // directed: range ends and duplicates
    add_word(-2147483648, 1'b0);
    add_word(1061109566, 1'b0);
    add_word(1061109567, 1'b0);
    add_word(2147483647, 1'b0);
    add_word(2147483647, 1'b0);
    add_word(-2147483648, 1'b0);
    add_word(-1, 1'b1);
    add_word(0, 1'b1);
    add_word(5, 1'b0);
    add_word(3, 1'b0);
    add_word(1, 1'b0);
    add_word(-5, 1'b1);
    add_word(7, 1'b0);
    add_word(7, 1'b0);
    add_word(7, 1'b1);
    add_word(1, 1'b0);
    add_word(2, 1'b0);
    add_word(3, 1'b0);
    add_word(2, 1'b0);
    add_word(4, 1'b1);
    add_word(32'h5555_5555, 1'b0);
    add_word(32'hAAAA_AAAA, 1'b1);

    while (value_queue.size() < 1950) begin
      if (fills < 2 && value_queue.size() > 500 + 700 * fills) begin
        // start the fill from an empty store so it really fills up
        value_queue[$].last_item = 1'b1;
        fill_store(fills[0]);
        fills++;
        continue;
      end
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3: begin
          len = $urandom_range(1, 20);
          style = $urandom_range(2);
          for (int i = 0; i < len; i++) add_word(pick_value(style), i == len - 1);
        end
        4, 5: begin
          // mostly rising with drops and repeats
          len = $urandom_range(5, 60);
          walk = -int'($urandom_range(100));
          for (int i = 0; i < len; i++) begin
            walk += int'($urandom_range(20)) - 4;
            add_word(walk, i == len - 1);
          end
        end
        6: begin
          len = $urandom_range(2, 30);
          walk = pick_value(1);
          for (int i = 0; i < len; i++) begin
            add_word(walk, i == len - 1);
            if (walk > -2147483000) walk -= int'($urandom_range(3));
          end
        end
        7: begin
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++) add_word(pick_value(1), $urandom_range(1));
        end
        default: begin
          // deep chain of 100..200 words
          len = $urandom_range(100, 200);
          walk = pick_value(2);
          for (int i = 0; i < len; i++) begin
            walk += int'($urandom_range(1, 50));
            add_word((i % 17 == 16) ? walk - 60 : walk, i == len - 1);
          end
        end
      endcase
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (value_queue.size() > 0) begin
        in_data <= value_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(7) == 0) begin
          burst_left = 200;
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(40);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: free runs and stall runs of random length, in random order.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run == 0) begin
      if ($urandom_range(2) == 0) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(1, 10);
      end else begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(1, 60);
      end
    end else begin
      stall_run--;
    end
  end

  always @(posedge clk) begin
    lis_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = track_value(in_data);
        level_queue.push_back(want);
        words_taken++;
        if (in_data.last_item) seq_closed++;
        if (want.overflow) ovf_seen++;
        if (want.level > peak_level) peak_level = want.level;
      end
      if (out_valid && !out_stall) begin
        if (level_queue.size() == 0) begin
          $error("result word with no expectation waiting");
          errors++;
        end else begin
          want = level_queue.pop_front();
          if (out_data.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, out_data.level);
            errors++;
          end
          if (out_data.longest !== want.longest) begin
            $error("longest: expected %0d, got %0d", want.longest, out_data.longest);
            errors++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    build_stimulus();
    total_words = value_queue.size();
    while (words_taken != total_words || level_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("summary: %0d words in %0d closed sequences, %0d overflow results, peak level %0d",
             words_taken, seq_closed, ovf_seen, peak_level);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
